### hdl/b40_pkg.sv
// Types, constants and character tables for the base-40 callsign codec.
// Shared by every module of the block but b40_fifo; no dependencies.
package b40_pkg;

    localparam int CODE_W  = 48;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int COUNT_W = 4;

    localparam logic [CODE_W-1:0] MAX_CODE = 48'hEE6B27FFFFFF;

    // Divide by 40 in 16-bit slices: v = rem*2^16 + slice < 40*2^16,
    // q = (v * RECIP) >> RECIP_SHIFT is exact over that range.
    localparam int SLICE_W     = 16;
    localparam int SLICES      = CODE_W / SLICE_W;
    localparam int STEP_W      = 2;
    localparam int VAL_W       = DIGIT_W + SLICE_W;
    localparam int RECIP_SHIFT = 27;
    localparam logic [VAL_W-1:0] RECIP = 22'd3355444;

    typedef enum logic [1:0] {
        OP_ENC,
        OP_DEC,
        OP_ERR
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_EMIT
    } t_bstate;

    typedef struct packed {
        logic              func;
        logic [CHAR_W-1:0] char_in;
        logic              last_char;
        logic [CODE_W-1:0] code_in;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic [CODE_W-1:0] code_out;
        logic              error;
        logic              last_out;
    } t_result;

    typedef struct packed {
        t_op                op;
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic [CODE_W-1:0]  code;
    } t_cmd;

    // Position in " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-/."; unknown maps to space.
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        case (c) inside
            8'h20:          d = 6'd0;
            [8'h41:8'h5A]:  d = DIGIT_W'(c - 8'h40);
            [8'h30:8'h39]:  d = DIGIT_W'(c - 8'h15);
            8'h2D:          d = 6'd37;
            8'h2F:          d = 6'd38;
            8'h2E:          d = 6'd39;
            default:        d = 6'd0;
        endcase
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] alpha_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d) inside
            6'd0:           c = 8'h20;
            [6'd1:6'd26]:   c = CHAR_W'(d) + 8'h40;
            [6'd27:6'd36]:  c = CHAR_W'(d) + 8'h15;
            6'd37:          c = 8'h2D;
            6'd38:          c = 8'h2F;
            6'd39:          c = 8'h2E;
            default:        c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hdl/b40_fifo.sv
// Small register queue used between the codec's stages.
// Generic in width and depth; no package dependencies.
module b40_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/b40_front.sv
// Front end: takes input beats, maps characters to digits and range-checks codes.
// Depends on b40_pkg.
module b40_front (
    input  logic              i_push,
    input  b40_pkg::t_in_item i_item,
    input  logic              i_cmd_full,
    output logic              o_full,
    output logic              o_cmd_wr,
    output b40_pkg::t_cmd     o_cmd
);
    import b40_pkg::*;

    logic accept;

    assign o_full = i_cmd_full;
    assign accept = i_push && !i_cmd_full;

    always_comb begin
        o_cmd.digit = digit_of(i_item.char_in);
        o_cmd.last  = i_item.last_char;
        o_cmd.code  = i_item.code_in;
        o_cmd_wr    = accept;
        if (!i_item.func) begin
            o_cmd.op = OP_ENC;
        end else if (i_item.code_in > MAX_CODE) begin
            o_cmd.op = OP_ERR;
        end else begin
            o_cmd.op = OP_DEC;
            // a zero code yields no characters, so it never reaches the back end
            if (i_item.code_in == '0) begin
                o_cmd_wr = 1'b0;
            end
        end
    end

endmodule

### hdl/b40_back.sv
// Back end: encode accumulator and sliced divide-by-40 decoder.
// Depends on b40_pkg.
module b40_back #(
    parameter int MAX_CHARS = 9
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  b40_pkg::t_cmd   i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  logic            i_res_full,
    output logic            o_res_wr,
    output b40_pkg::t_result o_res
);
    import b40_pkg::*;

    t_bstate             r_state, n_state;
    logic [CODE_W-1:0]   r_acc, n_acc;
    logic [CODE_W-1:0]   r_weight, n_weight;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [CODE_W-1:0]   r_dividend, n_dividend;
    logic [CODE_W-1:0]   r_quot, n_quot;
    logic [DIGIT_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;

    logic [CODE_W-1:0]   enc_term;
    logic [CODE_W-1:0]   enc_acc;
    logic                in_range;
    logic [VAL_W-1:0]    div_val;
    logic [2*VAL_W-1:0]  div_prod;
    logic [SLICE_W-1:0]  div_q;
    logic [VAL_W-1:0]    div_back;

    // digit * weight as six shifted partial products
    always_comb begin
        enc_term = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            if (i_cmd.digit[i]) begin
                enc_term = enc_term + (r_weight << i);
            end
        end
    end

    assign in_range = (r_count < COUNT_W'(MAX_CHARS));
    assign enc_acc  = in_range ? r_acc + enc_term : r_acc;

    assign div_val  = {r_rem, r_dividend[CODE_W-1 -: SLICE_W]};
    assign div_prod = div_val * RECIP;
    assign div_q    = div_prod[RECIP_SHIFT +: SLICE_W];
    // remainder = val - 40*q, with 40*q as (q << 5) + (q << 3)
    assign div_back = div_val - VAL_W'({div_q, 5'b0}) - VAL_W'({div_q, 3'b0});

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_DEC) begin
                    n_state = BS_DIV;
                end
            end
            BS_DIV: begin
                if (r_step == STEP_W'(SLICES - 1)) begin
                    n_state = BS_EMIT;
                end
            end
            BS_EMIT: begin
                if (!i_res_full) begin
                    n_state = (r_quot == '0) ? BS_IDLE : BS_DIV;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        n_acc      = r_acc;
        n_weight   = r_weight;
        n_count    = r_count;
        n_dividend = r_dividend;
        n_quot     = r_quot;
        n_rem      = r_rem;
        n_step     = r_step;
        o_cmd_pop  = 1'b0;
        o_res_wr   = 1'b0;
        o_res      = '0;
        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_ENC: begin
                            if (!i_res_full) begin
                                o_cmd_pop      = 1'b1;
                                o_res_wr       = 1'b1;
                                o_res.char_out = in_range ? alpha_char(i_cmd.digit) : '0;
                                o_res.last_out = i_cmd.last;
                                if (i_cmd.last) begin
                                    o_res.code_out = enc_acc;
                                    n_acc          = '0;
                                    n_weight       = CODE_W'(1);
                                    n_count        = '0;
                                end else if (in_range) begin
                                    n_acc    = enc_acc;
                                    n_weight = (r_weight << 5) + (r_weight << 3);
                                    n_count  = r_count + 1'b1;
                                end
                            end
                        end
                        OP_ERR: begin
                            if (!i_res_full) begin
                                o_cmd_pop      = 1'b1;
                                o_res_wr       = 1'b1;
                                o_res.error    = 1'b1;
                                o_res.last_out = 1'b1;
                            end
                        end
                        OP_DEC: begin
                            o_cmd_pop  = 1'b1;
                            n_dividend = i_cmd.code;
                            n_rem      = '0;
                            n_step     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            BS_DIV: begin
                n_dividend = r_dividend << SLICE_W;
                n_quot     = {r_quot[CODE_W-SLICE_W-1:0], div_q};
                n_rem      = div_back[DIGIT_W-1:0];
                n_step     = r_step + 1'b1;
            end
            BS_EMIT: begin
                if (!i_res_full) begin
                    o_res_wr       = 1'b1;
                    o_res.char_out = alpha_char(r_rem);
                    o_res.last_out = (r_quot == '0);
                    n_dividend     = r_quot;
                    n_rem          = '0;
                    n_step         = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_acc    <= '0;
            r_weight <= CODE_W'(1);
            r_count  <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_weight <= n_weight;
            r_count  <= n_count;
            r_step   <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dividend <= n_dividend;
        r_quot     <= n_quot;
        r_rem      <= n_rem;
    end

endmodule

### hdl/base40_callsign_codec.sv
// Base-40 callsign codec: encode one character per beat into a 48-bit code, or
// decode a 48-bit code into characters, least significant digit first. The back
// end encodes one character per cycle while the result queue has room. Decode
// gives at most 9 characters; each digit takes three passes of the 16-bit-slice
// divide-by-40 unit, then an emit step that waits while the result queue is full.
// A zero code gives no result, a code above 0xEE6B27FFFFFF gives one error result.
// Two-entry queues sit between front end and back end and ahead of the result port.
// Depends on b40_pkg, b40_fifo, b40_front and b40_back.
module base40_callsign_codec #(
    parameter int MAX_CHARS = 9,
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  b40_pkg::t_in_item i_item,
    output logic              empty,
    input  logic              pop,
    output b40_pkg::t_result  o_result
);
    import b40_pkg::*;

    logic    cmd_full, cmd_empty, cmd_wr, cmd_pop;
    t_cmd    cmd_in, cmd_out;
    logic    res_full, res_wr;
    t_result res_in;

    b40_front u_front (
        .i_push     (push),
        .i_item     (i_item),
        .i_cmd_full (cmd_full),
        .o_full     (full),
        .o_cmd_wr   (cmd_wr),
        .o_cmd      (cmd_in)
    );

    b40_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    b40_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res       (res_in)
    );

    b40_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    a_no_write_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> !res_full)
        else $error("result beat written into a full queue");

    a_no_pop_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from an empty queue");

    a_error_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error) |-> (o_result.last_out && o_result.char_out == '0))
        else $error("error beat not marked last");

    a_code_only_on_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.last_out) |-> (o_result.code_out == '0))
        else $error("code on a non-final beat");

endmodule

### tb/base40_callsign_codec_checker.sv
// Scoreboard for base40_callsign_codec: watches both queue ports, predicts the
// result beats of every accepted input beat and compares them in order.
// Depends on b40_pkg.
module base40_callsign_codec_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  logic              full,
    input  b40_pkg::t_in_item i_item,
    input  logic              empty,
    input  logic              pop,
    input  b40_pkg::t_result  o_result,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import b40_pkg::*;

    localparam string ALPHABET = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-/.";
    localparam int SYMBOLS = 40;
    localparam int CALLSIGN_MAX = 9;
    localparam logic [CODE_W-1:0] RADIX = CODE_W'(SYMBOLS);

    logic [CODE_W-1:0] callsign_code;
    logic [CODE_W-1:0] place_weight;
    int unsigned       chars_taken;
    t_result           pending_results[$];
    int                mismatch_count;

    function automatic logic [DIGIT_W-1:0] symbol_index(input logic [CHAR_W-1:0] c);
        for (int i = 0; i < SYMBOLS; i++) begin
            if (8'(ALPHABET[i]) == c) return DIGIT_W'(i);
        end
        return '0;
    endfunction

    task automatic derive_codec_results(input t_in_item it);
        t_result            r;
        logic [DIGIT_W-1:0] d;
        logic [CODE_W-1:0]  rem;
        int                 n;
        r = '0;
        if (it.func == 1'b0) begin
            // characters past the ninth leave the code alone and echo 0
            if (chars_taken < CALLSIGN_MAX) begin
                d = symbol_index(it.char_in);
                r.char_out = 8'(ALPHABET[d]);
                callsign_code = callsign_code + CODE_W'(d) * place_weight;
                place_weight = place_weight * RADIX;
                chars_taken++;
            end
            if (it.last_char) begin
                r.code_out = callsign_code;
                r.last_out = 1'b1;
                callsign_code = '0;
                place_weight = CODE_W'(1);
                chars_taken = 0;
            end
            pending_results.push_back(r);
        end else if (it.code_in > MAX_CODE) begin
            r.error = 1'b1;
            r.last_out = 1'b1;
            pending_results.push_back(r);
        end else begin
            // least significant digit first; a zero code gives nothing
            rem = it.code_in;
            n = 0;
            while (rem != '0 && n < CALLSIGN_MAX) begin
                r = '0;
                d = DIGIT_W'(rem % RADIX);
                rem = rem / RADIX;
                r.char_out = 8'(ALPHABET[d]);
                r.last_out = (rem == '0);
                pending_results.push_back(r);
                n++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            callsign_code = '0;
            place_weight = CODE_W'(1);
            chars_taken = 0;
            pending_results.delete();
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error({"unexpected result beat: char_out %02h code_out %012h",
                            " error %0b last_out %0b"},
                           o_result.char_out, o_result.code_out, o_result.error,
                           o_result.last_out);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.char_out !== want.char_out) begin
                        $error("char_out: expected %02h, actual %02h",
                               want.char_out, o_result.char_out);
                        mismatch_count++;
                    end
                    if (o_result.code_out !== want.code_out) begin
                        $error("code_out: expected %012h, actual %012h",
                               want.code_out, o_result.code_out);
                        mismatch_count++;
                    end
                    if (o_result.error !== want.error) begin
                        $error("error: expected %0b, actual %0b", want.error, o_result.error);
                        mismatch_count++;
                    end
                    if (o_result.last_out !== want.last_out) begin
                        $error("last_out: expected %0b, actual %0b",
                               want.last_out, o_result.last_out);
                        mismatch_count++;
                    end
                end
            end
            if (push && !full) derive_codec_results(i_item);
        end
        o_pending <= pending_results.size();
        o_fail_count <= mismatch_count;
    end

    initial begin
        mismatch_count = 0;
        o_pending = 0;
        o_fail_count = 0;
        callsign_code = '0;
        place_weight = CODE_W'(1);
        chars_taken = 0;
    end

endmodule

### tb/tb_base40_callsign_codec.sv
// Testbench top for base40_callsign_codec: directed callsigns and codes, then
// random callsigns and decode codes under varying port idling. Depends on
// b40_pkg, the codec RTL and base40_callsign_codec_checker.
module tb_base40_callsign_codec;
    timeunit 1ns;
    timeprecision 1ps;
    import b40_pkg::*;

    localparam string ALPHABET = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-/.";
    localparam int PHASE_ITEMS = 140;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    logic     full;
    t_in_item i_item;
    logic     empty;
    logic     pop;
    t_result  o_result;

    int fail_count;
    int pending_count;
    int send_idle_pct;
    int take_idle_pct;
    int items_sent;

    base40_callsign_codec uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    base40_callsign_codec_checker u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_item       (i_item),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random back-pressure at the current rate
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= take_idle_pct);
    end

    function automatic logic [CODE_W-1:0] noise48();
        return CODE_W'({$urandom, $urandom});
    endfunction

    // n random base-40 digits packed into a code
    function automatic logic [CODE_W-1:0] code_of_digits(input int n);
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] w;
        code = '0;
        w = CODE_W'(1);
        for (int i = 0; i < n; i++) begin
            code = code + CODE_W'($urandom_range(0, 39)) * w;
            w = w * CODE_W'(40);
        end
        return code;
    endfunction

    task automatic send_beat(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic encode_char(input logic [CHAR_W-1:0] c, input logic last);
        t_in_item it;
        it.func = 1'b0;
        it.char_in = c;
        it.last_char = last;
        it.code_in = noise48();
        send_beat(it);
    endtask

    task automatic decode_code(input logic [CODE_W-1:0] code);
        t_in_item it;
        it.func = 1'b1;
        it.char_in = CHAR_W'($urandom);
        it.last_char = 1'($urandom);
        it.code_in = code;
        send_beat(it);
    endtask

    task automatic random_decode();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            decode_code(code_of_digits($urandom_range(1, 9)));
        end else if (pick < 85) begin
            decode_code(noise48());
        end else begin
            case ($urandom_range(4))
                0: decode_code('0);
                1: decode_code(MAX_CODE);
                2: decode_code(MAX_CODE + CODE_W'($urandom_range(1, 1000)));
                3: decode_code(MAX_CODE - CODE_W'($urandom_range(0, 1000)));
                default: decode_code({CODE_W{1'b1}});
            endcase
        end
    endtask

    // mostly clean callsigns; some overlong, some with stray bytes or a decode inside
    task automatic random_callsign();
        int len;
        logic [CHAR_W-1:0] c;
        len = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 85) c = 8'(ALPHABET[$urandom_range(0, 39)]);
            else c = CHAR_W'($urandom_range(0, 255));
            encode_char(c, i == len - 1);
            if (i != len - 1 && $urandom_range(19) == 0) random_decode();
        end
    endtask

    task automatic run_random(input int target);
        while (items_sent < target) begin
            if ($urandom_range(99) < 70) random_callsign();
            else random_decode();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        items_sent = 0;
        send_idle_pct = 27;
        take_idle_pct = 52;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nine top symbols give the largest code, then two ignored beats
        for (int i = 0; i < 9; i++) encode_char(8'h2E, 1'b0);
        encode_char(8'h00, 1'b0);
        encode_char(8'hFF, 1'b1);
        encode_char(8'h20, 1'b1);
        decode_code('0);
        decode_code(MAX_CODE);
        decode_code(MAX_CODE + CODE_W'(1));
        decode_code({CODE_W{1'b1}});
        decode_code(CODE_W'(1));
        decode_code(CODE_W'(40));
        // decode in the middle of a callsign must not disturb it
        encode_char(8'h7A, 1'b0);
        decode_code(CODE_W'(39));
        encode_char(8'h39, 1'b1);

        run_random(items_sent + PHASE_ITEMS);
        send_idle_pct = 52;
        take_idle_pct = 27;
        run_random(items_sent + PHASE_ITEMS);
        send_idle_pct = 0;
        take_idle_pct = 0;
        run_random(items_sent + PHASE_ITEMS);
        push <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### base40_callsign_codec.f
hdl/b40_pkg.sv
hdl/b40_fifo.sv
hdl/b40_front.sv
hdl/b40_back.sv
hdl/base40_callsign_codec.sv
tb/base40_callsign_codec_checker.sv
tb/tb_base40_callsign_codec.sv
